// File: rtl/matrix3_inverse_core_assert.svh
// assertion macros for the 3x3 inverse core
// used by files that check their own pipeline control; no other dependencies
`ifndef MATRIX3_INVERSE_CORE_ASSERT_SVH
`define MATRIX3_INVERSE_CORE_ASSERT_SVH

// checked while out of reset
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define MI3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/mi3_pkg.sv
// types, widths and constant tables for the 3x3 inverse core
// no dependencies
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int EW = 32;
  localparam int CW = 2 * EW + 1;
  localparam int DW = 100;
  localparam int QW = EW - 1;
  localparam int NLANES = 9;

  localparam int COF_LAT = 2;
  localparam int DET_LAT = 3;
  localparam int DIV_LAT = QW + 3;
  localparam int PIPE_LAT = COF_LAT + DET_LAT + DIV_LAT;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;

  // cofactor k = a*b - c*d, negated where the neg bit is set
  localparam int COF_A [NLANES] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int COF_B [NLANES] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int COF_C [NLANES] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int COF_D [NLANES] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam logic [NLANES-1:0] COF_NEG = 9'b010101010;

  localparam elem_t SAT_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam elem_t SAT_MIN = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    elem_t det;
    logic  sing;
  } detres_t;

  typedef struct packed {
    logic [NLANES-1:0][EW-1:0] inv;
    elem_t                     det;
    logic                      sing;
  } res_t;

endpackage

// File: rtl/mi3_if.sv
// valid/ready channel interfaces for matrix input and inverse result
// depends on mi3_pkg
`timescale 1ns / 1ps
interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t a11, a12, a13, a21, a22, a23, a31, a32, a33;
  modport source (output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, input ready);
  modport sink (input valid, a11, a12, a13, a21, a22, a23, a31, a32, a33, output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33;
  elem_t determinant;
  logic  singular;
  modport source (output valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32,
                  inv33, determinant, singular, input ready);
  modport sink (input valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32,
                inv33, determinant, singular, output ready);
endinterface

// File: rtl/matrix3_inverse_core.sv
// 3x3 fixed-point matrix inverse by adjugate over determinant
// throughput: one matrix per cycle while the skid stage is empty; nine divider lanes of 31 one-bit stages each
// output register plus skid stage, input ready depends only on the skid stage
// reset (async, active low) clears all valid bits; data registers are not reset
// depends on mi3_pkg, mi3_if, mi3_cof, mi3_det, mi3_div and matrix3_inverse_core_assert.svh
`timescale 1ns / 1ps
module matrix3_inverse_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mi3_in_if.sink           in_i,
  mi3_out_if.source        out_o
);
  import mi3_pkg::*;
  `include "matrix3_inverse_core_assert.svh"

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;
  elem_t               m [NLANES];
  cof_t                adj [NLANES];
  cof_t                adj1_q [NLANES], adj2_q [NLANES], adj3_q [NLANES];
  elem_t               mrow1_q [3], mrow2_q [3];
  cof_t                ccol [3];
  det_t                det;
  elem_t               inv [NLANES];

  logic                det_neg, det_big;
  logic [DW-1:0]       det_abs, det_sh;
  detres_t             dres;
  detres_t             dres_q [DIV_LAT];

  res_t                tail, out_q, skid_q;
  logic                out_vld_q, skid_vld_q, push;

  assign m[0] = in_i.a11;
  assign m[1] = in_i.a12;
  assign m[2] = in_i.a13;
  assign m[3] = in_i.a21;
  assign m[4] = in_i.a22;
  assign m[5] = in_i.a23;
  assign m[6] = in_i.a31;
  assign m[7] = in_i.a32;
  assign m[8] = in_i.a33;

  assign en         = !skid_vld_q;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_i.valid};
    end
  end

  // cofactor lanes
  for (genvar k = 0; k < NLANES; k++) begin : g_cof
    mi3_cof #(.NEG(COF_NEG[k])) u_cof (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (m[COF_A[k]]),
      .b_i   (m[COF_B[k]]),
      .c_i   (m[COF_C[k]]),
      .d_i   (m[COF_D[k]]),
      .cof_o (adj[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mrow1_q[j] <= m[j];
        mrow2_q[j] <= mrow1_q[j];
      end
      for (int k = 0; k < NLANES; k++) begin
        adj1_q[k] <= adj[k];
        adj2_q[k] <= adj1_q[k];
        adj3_q[k] <= adj2_q[k];
      end
    end
  end

  assign ccol[0] = adj[0];
  assign ccol[1] = adj[3];
  assign ccol[2] = adj[6];

  mi3_det u_det (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   (mrow2_q),
    .c_i   (ccol),
    .det_o (det)
  );

  // divider lanes
  for (genvar k = 0; k < NLANES; k++) begin : g_div
    mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .cof_i (adj3_q[k]),
      .det_i (det),
      .inv_o (inv[k])
    );
  end

  // determinant rescale and saturation
  assign det_neg = det[DW-1];
  assign det_abs = det_neg ? DW'(-det) : DW'(det);
  assign det_sh  = det_abs >> (2 * FRAC_BITS);
  assign det_big = |det_sh[DW-1:QW];

  always_comb begin
    dres.sing = (det == '0);
    if (det_big) begin
      dres.det = det_neg ? SAT_MIN : SAT_MAX;
    end else if (det_neg) begin
      dres.det = -$signed({1'b0, det_sh[QW-1:0]});
    end else begin
      dres.det = $signed({1'b0, det_sh[QW-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dres_q[0] <= dres;
      for (int s = 1; s < DIV_LAT; s++) begin
        dres_q[s] <= dres_q[s-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NLANES; k++) begin
      tail.inv[k] = inv[k];
    end
    tail.det  = dres_q[DIV_LAT-1].det;
    tail.sing = dres_q[DIV_LAT-1].sing;
  end

  // output register and skid stage
  assign push = en && vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && out_o.ready) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push;
      end
    end else if (!out_vld_q) begin
      out_vld_q <= push;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && out_o.ready) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= tail;
      end
    end else if (!out_vld_q) begin
      if (push) begin
        out_q <= tail;
      end
    end else if (push) begin
      skid_q <= tail;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.inv11       = out_q.inv[0];
  assign out_o.inv12       = out_q.inv[1];
  assign out_o.inv13       = out_q.inv[2];
  assign out_o.inv21       = out_q.inv[3];
  assign out_o.inv22       = out_q.inv[4];
  assign out_o.inv23       = out_q.inv[5];
  assign out_o.inv31       = out_q.inv[6];
  assign out_o.inv32       = out_q.inv[7];
  assign out_o.inv33       = out_q.inv[8];
  assign out_o.determinant = out_q.det;
  assign out_o.singular    = out_q.sing;

  `MI3_ASSERT_ALWAYS(a_skid_needs_out, skid_vld_q |-> out_vld_q, "skid without output")
  `MI3_ASSERT(a_skid_fill, $rose(skid_vld_q) |-> $past(out_vld_q && !out_o.ready), "skid fill")
  `MI3_ASSERT(a_sing_zero, out_vld_q && out_q.sing |-> out_q.det == '0 && out_q.inv == '0, "nonzero")
endmodule

// File: rtl/mi3_cof.sv
// one cofactor lane: two products, then their difference
// depends on mi3_pkg
`timescale 1ns / 1ps
module mi3_cof #(
  parameter bit NEG = 1'b0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  mi3_pkg::elem_t a_i,
  input  mi3_pkg::elem_t b_i,
  input  mi3_pkg::elem_t c_i,
  input  mi3_pkg::elem_t d_i,
  output mi3_pkg::cof_t  cof_o
);
  import mi3_pkg::*;

  logic signed [2*EW-1:0] p1_q, p2_q;
  cof_t                   cof_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= a_i * b_i;
      p2_q <= c_i * d_i;
      if (NEG) begin
        cof_q <= CW'(p2_q) - CW'(p1_q);
      end else begin
        cof_q <= CW'(p1_q) - CW'(p2_q);
      end
    end
  end

  assign cof_o = cof_q;
endmodule

// File: rtl/mi3_det.sv
// merge stage: determinant from the first row and its cofactors
// depends on mi3_pkg
`timescale 1ns / 1ps
module mi3_det (
  input  logic           clk_i,
  input  logic           en_i,
  input  mi3_pkg::elem_t m_i [3],
  input  mi3_pkg::cof_t  c_i [3],
  output mi3_pkg::det_t  det_o
);
  import mi3_pkg::*;

  logic signed [CW-1:0] plo_q [3];
  logic signed [CW-1:0] phi_q [3];
  det_t                 term_q [3];
  det_t                 det_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j]  <= m_i[j] * $signed({1'b0, c_i[j][EW-1:0]});
        phi_q[j]  <= m_i[j] * $signed(c_i[j][CW-1:EW]);
        term_q[j] <= (DW'(phi_q[j]) <<< EW) + DW'(plo_q[j]);
      end
      det_q <= term_q[0] + term_q[1] + term_q[2];
    end
  end

  assign det_o = det_q;
endmodule

// File: rtl/mi3_div.sv
// divider lane: cofactor scaled by 2^(2F) over determinant, one quotient bit per stage
// depends on mi3_pkg
`timescale 1ns / 1ps
module mi3_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  mi3_pkg::cof_t  cof_i,
  input  mi3_pkg::det_t  det_i,
  output mi3_pkg::elem_t inv_o
);
  import mi3_pkg::*;

  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] nmag_q;
  logic [DW-1:0] dmag1_q;
  logic          neg1_q, zero1_q;

  logic [RW-1:0] rem_q  [QW+1];
  logic [DW-1:0] dmag_q [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic          neg_q  [QW+1];
  logic          ovf_q  [QW+1];
  logic          zero_q [QW+1];

  logic [RW-1:0] nwide, dlim;
  elem_t         res, inv_q;

  // magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q  <= cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
      dmag1_q <= det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
      neg1_q  <= cof_i[CW-1] ^ det_i[DW-1];
      zero1_q <= (det_i == '0);
    end
  end

  // quotient overflow check
  assign nwide = {{(RW-CW){1'b0}}, nmag_q} << (2 * FRAC_BITS);
  assign dlim  = {{(RW-DW){1'b0}}, dmag1_q} << QW;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= nwide;
      dmag_q[0] <= dmag1_q;
      quo_q[0]  <= '0;
      neg_q[0]  <= neg1_q;
      ovf_q[0]  <= (nwide >= dlim);
      zero_q[0] <= zero1_q;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int BI = QW - s;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = {{(RW-DW){1'b0}}, dmag_q[s-1]} << BI;
    assign ge  = (rem_q[s-1] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? rem_q[s-1] - dsh : rem_q[s-1];
        quo_q[s]  <= quo_q[s-1] | (QW'(ge) << BI);
        dmag_q[s] <= dmag_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  always_comb begin
    if (zero_q[QW]) begin
      res = '0;
    end else if (ovf_q[QW]) begin
      res = neg_q[QW] ? SAT_MIN : SAT_MAX;
    end else if (neg_q[QW]) begin
      res = -$signed({1'b0, quo_q[QW]});
    end else begin
      res = $signed({1'b0, quo_q[QW]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inv_q <= res;
    end
  end

  assign inv_o = inv_q;
endmodule
